// ===== src/bpfa_pkg.sv =====
// Bitmap page frame allocator: shared constants, codes, types and helper functions.
// No dependencies.
`timescale 1ns / 1ps

package bpfa_pkg;

	localparam int WORD_BITS      = 32;
	localparam int WORD_SH        = 5;
	localparam int GROUP_BITS     = 32;
	localparam int GROUP_SH       = 10;
	localparam int FRAME_SHIFT    = 12;
	localparam int ADDR_W         = 32;
	localparam int FR_W           = ADDR_W - FRAME_SHIFT;
	localparam int LIM_W          = FR_W + 1;
	localparam int FC_W           = 16;
	localparam int MAX_FRAMES_DEF = 32768;

	localparam logic [FC_W-1:0]   FC_RESET  = 16'd32768;
	localparam logic [ADDR_W-1:0] ADDR_FAIL = '1;

	typedef enum logic [1:0] {
		FN_ALLOC   = 2'd0,
		FN_FREE    = 2'd1,
		FN_RESERVE = 2'd2,
		FN_NONE    = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_NOFREE = 2'd1,
		STAT_RANGE  = 2'd2,
		STAT_RSVD   = 2'd3
	} stat_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ASUM,
		S_AWORD,
		S_FRD,
		S_MOD,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]        func;
		logic [ADDR_W-1:0] frame_address;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] address;
		logic [1:0]        status;
	} rsp_t;

	// lowest bit position that holds a zero, LSB first
	function automatic logic [4:0] first_zero_lsb(logic [GROUP_BITS-1:0] v);
		logic [4:0] r;
		r = '0;
		for (int i = GROUP_BITS - 1; i >= 0; i--) begin
			if (!v[i]) begin
				r = 5'(i);
			end
		end
		return r;
	endfunction

	// offset from the MSB of the first zero bit
	function automatic logic [4:0] first_zero_msb(logic [WORD_BITS-1:0] v);
		logic [4:0] r;
		r = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (!v[i]) begin
				r = 5'(WORD_BITS - 1 - i);
			end
		end
		return r;
	endfunction

endpackage

// ===== src/bpfa_if.sv =====
// Handshake channel interfaces: request, response and configuration write.
// Depends on bpfa_pkg.
`timescale 1ns / 1ps

interface bpfa_req_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    func;
	logic [bpfa_pkg::ADDR_W-1:0]   frame_address;

	modport source (output valid, output func, output frame_address, input ready);
	modport sink   (input valid, input func, input frame_address, output ready);
endinterface

interface bpfa_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [bpfa_pkg::ADDR_W-1:0]   address;
	logic [1:0]                    status;

	modport source (output valid, output address, output status, input ready);
	modport sink   (input valid, input address, input status, output ready);
endinterface

interface bpfa_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [bpfa_pkg::FC_W-1:0]     frame_count;

	modport source (output valid, output frame_count, input ready);
	modport sink   (input valid, input frame_count, output ready);
endinterface

// ===== src/bpfa_core.sv =====
// Allocator engine: bitmap memory, word-full summary memory, group-full flags, control FSM.
// Depends on bpfa_pkg.
`timescale 1ns / 1ps

module bpfa_core #(
	parameter int MAX_FRAMES = bpfa_pkg::MAX_FRAMES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  bpfa_pkg::req_t              in_req,
	input  logic [bpfa_pkg::LIM_W-1:0]  limit,
	output logic                        res_valid,
	input  logic                        res_ready,
	output bpfa_pkg::rsp_t              res
);

	localparam int NUM_WORDS  = (MAX_FRAMES + bpfa_pkg::WORD_BITS - 1) / bpfa_pkg::WORD_BITS;
	localparam int NUM_GROUPS = (NUM_WORDS + bpfa_pkg::GROUP_BITS - 1) / bpfa_pkg::GROUP_BITS;
	localparam int WA_W       = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int GA_W       = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

	bpfa_pkg::state_t state_q, state_d;

	logic [bpfa_pkg::WORD_BITS-1:0]  mem [NUM_WORDS];
	logic [bpfa_pkg::GROUP_BITS-1:0] sum [NUM_GROUPS];
	logic [bpfa_pkg::WORD_BITS-1:0]  mem_rd_q;
	logic [bpfa_pkg::GROUP_BITS-1:0] sum_rd_q;

	logic [WA_W-1:0]             clr_q;
	logic [NUM_GROUPS-1:0]       full_q;
	logic [bpfa_pkg::FR_W-1:0]   f_q;
	logic [1:0]                  func_q;
	bpfa_pkg::rsp_t              res_q;

	logic                        mem_re, mem_we, sum_re, sum_we;
	logic [WA_W-1:0]             mem_idx;
	logic [GA_W-1:0]             sum_idx;
	logic [bpfa_pkg::WORD_BITS-1:0]  mem_wd;
	logic [bpfa_pkg::GROUP_BITS-1:0] sum_wd;

	logic                        clr_last, clr_sum;
	logic                        accept;
	logic [GA_W-1:0]             g_sel;
	logic [bpfa_pkg::FR_W-1:0]   in_frame;
	logic                        in_range;
	logic [4:0]                  k_sel;
	logic [4:0]                  j_sel;
	logic [bpfa_pkg::FR_W-1:0]   f_alloc;
	logic                        alloc_ok;
	logic [4:0]                  bit_off;
	logic [bpfa_pkg::WORD_BITS-1:0]  bit_mask;
	logic [bpfa_pkg::WORD_BITS-1:0]  word_new;
	logic [bpfa_pkg::GROUP_BITS-1:0] sum_new;
	logic                        is_alloc;
	logic                        do_write;
	logic [GA_W-1:0]             g_cur;

	assign clr_last = (clr_q == WA_W'(NUM_WORDS - 1));
	assign clr_sum  = ({1'b0, clr_q} < (WA_W + 1)'(NUM_GROUPS));
	assign accept   = in_valid && in_ready;
	assign in_frame = in_req.frame_address[bpfa_pkg::ADDR_W-1:bpfa_pkg::FRAME_SHIFT];
	assign in_range = ({1'b0, in_frame} < limit);
	assign is_alloc = (func_q == bpfa_pkg::FN_ALLOC);
	assign g_cur    = GA_W'(f_q >> bpfa_pkg::GROUP_SH);

	always_comb begin
		g_sel = '0;
		for (int i = NUM_GROUPS - 1; i >= 0; i--) begin
			if (!full_q[i]) begin
				g_sel = GA_W'(i);
			end
		end
	end

	assign k_sel    = bpfa_pkg::first_zero_lsb(sum_rd_q);
	assign j_sel    = bpfa_pkg::first_zero_msb(mem_rd_q);
	assign f_alloc  = {f_q[bpfa_pkg::FR_W-1:bpfa_pkg::WORD_SH], j_sel};
	assign alloc_ok = ({1'b0, f_alloc} < limit);
	assign bit_off  = is_alloc ? j_sel : f_q[bpfa_pkg::WORD_SH-1:0];
	assign bit_mask = bpfa_pkg::WORD_BITS'(1) << (~bit_off);
	assign word_new = (func_q == bpfa_pkg::FN_FREE) ? (mem_rd_q & ~bit_mask)
							: (mem_rd_q | bit_mask);
	assign do_write = !is_alloc || alloc_ok;

	always_comb begin
		sum_new = sum_rd_q;
		sum_new[f_q[bpfa_pkg::GROUP_SH-1:bpfa_pkg::WORD_SH]] = &word_new;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bpfa_pkg::S_CLEAR: begin
				if (clr_last) begin
					state_d = bpfa_pkg::S_IDLE;
				end
			end
			bpfa_pkg::S_IDLE: begin
				if (accept) begin
					case (in_req.func)
						bpfa_pkg::FN_ALLOC: begin
							state_d = (&full_q) ? bpfa_pkg::S_DONE : bpfa_pkg::S_ASUM;
						end
						bpfa_pkg::FN_FREE, bpfa_pkg::FN_RESERVE: begin
							state_d = in_range ? bpfa_pkg::S_FRD : bpfa_pkg::S_DONE;
						end
						default: state_d = bpfa_pkg::S_DONE;
					endcase
				end
			end
			bpfa_pkg::S_ASUM:  state_d = bpfa_pkg::S_AWORD;
			bpfa_pkg::S_AWORD: state_d = bpfa_pkg::S_MOD;
			bpfa_pkg::S_FRD:   state_d = bpfa_pkg::S_MOD;
			bpfa_pkg::S_MOD:   state_d = bpfa_pkg::S_DONE;
			bpfa_pkg::S_DONE: begin
				if (res_ready) begin
					state_d = bpfa_pkg::S_IDLE;
				end
			end
			default: state_d = bpfa_pkg::S_CLEAR;
		endcase
	end

	// outputs and memory controls
	always_comb begin
		in_ready  = 1'b0;
		res_valid = 1'b0;
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		sum_re    = 1'b0;
		sum_we    = 1'b0;
		mem_idx   = WA_W'(f_q >> bpfa_pkg::WORD_SH);
		sum_idx   = g_cur;
		mem_wd    = word_new;
		sum_wd    = sum_new;
		unique case (state_q)
			bpfa_pkg::S_CLEAR: begin
				mem_we  = 1'b1;
				sum_we  = clr_sum;
				mem_idx = clr_q;
				sum_idx = GA_W'(clr_q);
				mem_wd  = '1;
				sum_wd  = '1;
			end
			bpfa_pkg::S_IDLE: begin
				in_ready = 1'b1;
			end
			bpfa_pkg::S_ASUM: begin
				sum_re = 1'b1;
			end
			bpfa_pkg::S_AWORD: begin
				mem_re  = 1'b1;
				mem_idx = WA_W'({g_cur, k_sel});
			end
			bpfa_pkg::S_FRD: begin
				mem_re = 1'b1;
				sum_re = 1'b1;
			end
			bpfa_pkg::S_MOD: begin
				mem_we = do_write;
				sum_we = do_write;
			end
			bpfa_pkg::S_DONE: begin
				res_valid = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_idx] <= mem_wd;
		end
		if (mem_re) begin
			mem_rd_q <= mem[mem_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (sum_we) begin
			sum[sum_idx] <= sum_wd;
		end
		if (sum_re) begin
			sum_rd_q <= sum[sum_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bpfa_pkg::S_CLEAR;
			clr_q   <= '0;
			full_q  <= '1;
		end else begin
			state_q <= state_d;
			if (state_q == bpfa_pkg::S_CLEAR) begin
				clr_q <= clr_q + WA_W'(1);
			end
			if (state_q == bpfa_pkg::S_MOD && do_write) begin
				full_q[g_cur] <= &sum_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= in_req.func;
			f_q    <= (in_req.func == bpfa_pkg::FN_ALLOC)
					? (bpfa_pkg::FR_W'(g_sel) << bpfa_pkg::GROUP_SH) : in_frame;
			if (in_req.func == bpfa_pkg::FN_ALLOC && (&full_q)) begin
				res_q <= '{address: bpfa_pkg::ADDR_FAIL, status: bpfa_pkg::STAT_NOFREE};
			end else if ((in_req.func == bpfa_pkg::FN_FREE
					|| in_req.func == bpfa_pkg::FN_RESERVE) && !in_range) begin
				res_q <= '{address: '0, status: bpfa_pkg::STAT_RANGE};
			end else begin
				res_q <= '{address: '0, status: bpfa_pkg::STAT_OK};
			end
		end
		if (state_q == bpfa_pkg::S_AWORD) begin
			f_q[bpfa_pkg::GROUP_SH-1:bpfa_pkg::WORD_SH] <= k_sel;
		end
		if (state_q == bpfa_pkg::S_MOD && is_alloc) begin
			if (alloc_ok) begin
				res_q <= '{address: bpfa_pkg::ADDR_W'(f_alloc) << bpfa_pkg::FRAME_SHIFT,
						status: bpfa_pkg::STAT_OK};
			end else begin
				res_q <= '{address: bpfa_pkg::ADDR_FAIL, status: bpfa_pkg::STAT_NOFREE};
			end
		end
	end

	assign res = res_q;

endmodule

// ===== src/bitmap_page_frame_allocator_top.sv =====
// Bitmap page frame allocator, first fit, top level: config register and response register.
// Depends on bpfa_pkg, bpfa_if (interfaces) and bpfa_core.
//
//  channel  dir  payload                     transaction
//  req      in   func, frame_address         valid & ready
//  rsp      out  address, status             valid & ready
//  cfg      in   frame_count                 valid & ready (always ready)
//
// One request at a time, set by the read-modify-write sequence on the bitmap and summary RAMs.
// Allocate reads the summary word, then the bitmap word, then writes both; free/reserve read both, then write.
// After reset a clearing pass writes all RAM words to used, req.ready low during it. The
// response register lets the engine finish and take one more request while a response
// waits on rsp.ready.
`timescale 1ns / 1ps

module bitmap_page_frame_allocator_top #(
	parameter int MAX_FRAMES = bpfa_pkg::MAX_FRAMES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	bpfa_req_if.sink       req,
	bpfa_rsp_if.source     rsp,
	bpfa_cfg_if.sink       cfg
);

	localparam logic [bpfa_pkg::LIM_W-1:0] MAX_LIM = bpfa_pkg::LIM_W'(MAX_FRAMES);

	logic [bpfa_pkg::FC_W-1:0]  fc_q;
	logic [bpfa_pkg::LIM_W-1:0] limit;
	logic                       out_valid_q;
	bpfa_pkg::rsp_t             out_q;
	bpfa_pkg::req_t             in_req;
	bpfa_pkg::rsp_t             core_res;
	logic                       core_valid;
	logic                       core_ready;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q <= bpfa_pkg::FC_RESET;
		end else if (cfg.valid) begin
			fc_q <= cfg.frame_count;
		end
	end

	assign limit = (bpfa_pkg::LIM_W'(fc_q) < MAX_LIM) ? bpfa_pkg::LIM_W'(fc_q) : MAX_LIM;

	assign in_req = '{func: req.func, frame_address: req.frame_address};

	bpfa_core #(
		.MAX_FRAMES (MAX_FRAMES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.in_req    (in_req),
		.limit     (limit),
		.res_valid (core_valid),
		.res_ready (core_ready),
		.res       (core_res)
	);

	assign core_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (core_ready) begin
			out_valid_q <= core_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (core_ready && core_valid) begin
			out_q <= core_res;
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.address = out_q.address;
	assign rsp.status  = out_q.status;

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the bitmap page frame allocator (first fit).
// Depends on src/bpfa_pkg.sv, src/bpfa_if.sv and bitmap_page_frame_allocator_top.
// Directed table of requests and frame_count writes, then random traffic under handshake stalls.
`timescale 1ns / 1ps

module testbench;
	import bpfa_pkg::*;

	localparam int MAX_FRAMES = MAX_FRAMES_DEF;
	localparam int NUM_WORDS  = MAX_FRAMES / WORD_BITS;

	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

	typedef struct {
		row_kind_e         kind;
		func_t             fn;
		logic [ADDR_W-1:0] arg;
		bit                typed;
		logic [ADDR_W-1:0] exp_address;
		stat_t             exp_status;
	} step_row_t;

	typedef struct packed {
		logic [ADDR_W-1:0] address;
		stat_t             status;
	} answer_t;

	logic clk;
	logic arst_n;

	bpfa_req_if req_bus ();
	bpfa_rsp_if rsp_bus ();
	bpfa_cfg_if cfg_bus ();

	bitmap_page_frame_allocator_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus),
		.cfg    (cfg_bus)
	);

	logic [WORD_BITS-1:0] frame_map [NUM_WORDS];
	logic [FC_W-1:0]      frame_count_q;
	answer_t              expected_answers [$];
	step_row_t            directed_rows [$];

	int          err_count;
	int          tx_idle_pct;
	int          rx_idle_pct;
	int unsigned hold_ask;
	int          n_req, n_granted, n_refused, n_range, n_cfg;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("testbench: done, errors");
		$finish;
	end

	function automatic int unsigned active_limit();
		return (frame_count_q < MAX_FRAMES) ? int'(frame_count_q) : MAX_FRAMES;
	endfunction

	// predicts each answer; alloc is a first-fit search for a zero (free) bit, MSB of each word is the lowest frame
	function automatic answer_t predict_frame_op(func_t fn, logic [ADDR_W-1:0] a);
		answer_t     ans;
		int unsigned lim, fr, w, b;
		bit          hit;
		ans.address = '0;
		ans.status  = STAT_OK;
		hit = 1'b0;
		lim = active_limit();
		case (fn)
			FN_ALLOC: begin
				for (w = 0; w < NUM_WORDS && w * WORD_BITS < lim && !hit; w++) begin
					if (frame_map[w] != '1) begin
						for (b = 0; b < WORD_BITS && !hit; b++) begin
							fr = w * WORD_BITS + b;
							if (fr < lim && !frame_map[w][WORD_BITS-1-b]) begin
								frame_map[w][WORD_BITS-1-b] = 1'b1;
								ans.address = fr << FRAME_SHIFT;
								hit = 1'b1;
							end
						end
					end
				end
				if (hit) begin
					n_granted++;
				end else begin
					ans.address = ADDR_FAIL;
					ans.status  = STAT_NOFREE;
					n_refused++;
				end
			end
			FN_FREE, FN_RESERVE: begin
				fr = a >> FRAME_SHIFT;
				if (fr >= lim) begin
					ans.status = STAT_RANGE;
					n_range++;
				end else begin
					frame_map[fr / WORD_BITS][WORD_BITS-1-(fr % WORD_BITS)] = (fn == FN_RESERVE);
				end
			end
			default: begin
			end
		endcase
		return ans;
	endfunction

	function automatic void add_row(row_kind_e k, func_t fn, logic [ADDR_W-1:0] arg, bit typed,
			logic [ADDR_W-1:0] ea, stat_t es);
		step_row_t row;
		row.kind        = k;
		row.fn          = fn;
		row.arg         = arg;
		row.typed       = typed;
		row.exp_address = ea;
		row.exp_status  = es;
		directed_rows.push_back(row);
	endfunction

	function automatic logic [FC_W-1:0] pick_frame_count();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return FC_RESET;
			3: return FC_W'($urandom);
			4: return 16'd32767;
			default: return FC_W'($urandom_range(1, 96));
		endcase
	endfunction

	// mostly frames near the bottom or the edge of the active range
	function automatic logic [ADDR_W-1:0] pick_address();
		int unsigned lim, fr, r, low;
		lim = active_limit();
		r   = $urandom_range(99);
		low = $urandom_range(4095);
		if (r < 70) begin
			fr = $urandom_range(0, ((lim < 128) ? lim : 128) + 1);
		end else if (r < 80) begin
			fr = (lim == 0) ? 0 : lim - 1 + $urandom_range(0, 1);
		end else if (r < 90) begin
			fr = $urandom_range(0, MAX_FRAMES - 1);
		end else begin
			return $urandom;
		end
		return {fr[FR_W-1:0], low[FRAME_SHIFT-1:0]};
	endfunction

	function automatic func_t pick_func();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 45) return FN_ALLOC;
		if (r < 78) return FN_FREE;
		if (r < 95) return FN_RESERVE;
		return FN_NONE;
	endfunction

	task automatic issue_request(func_t fn, logic [ADDR_W-1:0] a, bit typed,
			logic [ADDR_W-1:0] ea, stat_t es);
		answer_t ans;
		while ($urandom_range(99) < tx_idle_pct) begin
			req_bus.valid <= 1'b0;
			@(posedge clk);
		end
		req_bus.valid         <= 1'b1;
		req_bus.func          <= fn;
		req_bus.frame_address <= a;
		@(posedge clk);
		while (!req_bus.ready) @(posedge clk);
		n_req++;
		ans = predict_frame_op(fn, a);
		if (typed) begin
			ans.address = ea;
			ans.status  = es;
		end
		expected_answers.push_back(ans);
	endtask

	// register writes only once every answer is back and the engine has settled
	task automatic write_frame_count(logic [FC_W-1:0] v);
		req_bus.valid <= 1'b0;
		while (expected_answers.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_bus.valid       <= 1'b1;
		cfg_bus.frame_count <= v;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
		frame_count_q = v;
		n_cfg++;
		cfg_bus.valid <= 1'b0;
	endtask

	// response side: ready pattern, long hold-offs and checking
	initial begin
		int unsigned hold_left;
		answer_t     want;
		hold_left = 0;
		rsp_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_bus.valid && rsp_bus.ready) begin
				if (expected_answers.size() == 0) begin
					$error("unexpected transaction: address %h status %0d",
						rsp_bus.address, rsp_bus.status);
					err_count++;
				end else begin
					want = expected_answers.pop_front();
					if (rsp_bus.address !== want.address) begin
						$error("address: expected %h, got %h", want.address, rsp_bus.address);
						err_count++;
					end
					if (rsp_bus.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp_bus.status);
						err_count++;
					end
				end
			end
			if (hold_ask != 0) begin
				hold_left = hold_ask;
				hold_ask  = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				rsp_bus.ready <= 1'b0;
			end else begin
				rsp_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	initial begin
		step_row_t row;
		int        phase, blk, i;
		arst_n = 1'b0;
		req_bus.valid = 1'b0;
		req_bus.func = FN_NONE;
		req_bus.frame_address = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.frame_count = '0;
		err_count = 0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_ask = 0;
		n_req = 0;
		n_granted = 0;
		n_refused = 0;
		n_range = 0;
		n_cfg = 0;
		for (i = 0; i < NUM_WORDS; i++) frame_map[i] = '1;
		frame_count_q = FC_RESET;

		add_row(ROW_REQ, FN_ALLOC,   32'h0000_0000, 1, ADDR_FAIL,     STAT_NOFREE);
		add_row(ROW_REQ, FN_FREE,    32'h0000_0FFF, 1, '0,            STAT_OK);
		add_row(ROW_REQ, FN_ALLOC,   32'hFFFF_FFFF, 1, '0,            STAT_OK);
		add_row(ROW_REQ, FN_ALLOC,   32'h0000_0000, 1, ADDR_FAIL,     STAT_NOFREE);
		add_row(ROW_REQ, FN_FREE,    32'h07FF_F000, 1, '0,            STAT_OK);
		add_row(ROW_REQ, FN_FREE,    32'h0800_0000, 1, '0,            STAT_RANGE);
		add_row(ROW_REQ, FN_RESERVE, 32'hFFFF_FFFF, 1, '0,            STAT_RANGE);
		add_row(ROW_REQ, FN_NONE,    32'hFFFF_FFFF, 1, '0,            STAT_OK);
		add_row(ROW_REQ, FN_ALLOC,   32'h0000_0000, 1, 32'h07FF_F000, STAT_OK);
		add_row(ROW_REQ, FN_FREE,    32'h0000_5000, 1, '0,            STAT_OK);
		add_row(ROW_REQ, FN_FREE,    32'h0000_5ABC, 1, '0,            STAT_OK);
		add_row(ROW_REQ, FN_RESERVE, 32'h0000_5000, 1, '0,            STAT_OK);
		add_row(ROW_REQ, FN_RESERVE, 32'h0000_5000, 1, '0,            STAT_OK);
		add_row(ROW_REQ, FN_FREE,    32'h0000_5000, 0, '0,            STAT_OK);
		add_row(ROW_REQ, FN_FREE,    32'h0000_3000, 0, '0,            STAT_OK);
		add_row(ROW_REQ, FN_ALLOC,   32'h0000_0000, 0, '0,            STAT_OK);
		add_row(ROW_REQ, FN_ALLOC,   32'h0000_0000, 0, '0,            STAT_OK);
		add_row(ROW_CFG, FN_NONE,    32'd0,         0, '0,            STAT_OK);
		add_row(ROW_REQ, FN_ALLOC,   32'h0000_0000, 1, ADDR_FAIL,     STAT_NOFREE);
		add_row(ROW_REQ, FN_FREE,    32'h0000_0000, 1, '0,            STAT_RANGE);
		add_row(ROW_REQ, FN_RESERVE, 32'h0000_0000, 1, '0,            STAT_RANGE);
		add_row(ROW_CFG, FN_NONE,    32'd4,         0, '0,            STAT_OK);
		add_row(ROW_REQ, FN_FREE,    32'h0000_4000, 1, '0,            STAT_RANGE);
		add_row(ROW_REQ, FN_FREE,    32'h0000_3000, 1, '0,            STAT_OK);
		add_row(ROW_REQ, FN_ALLOC,   32'h0000_0000, 0, '0,            STAT_OK);
		add_row(ROW_CFG, FN_NONE,    32'd65535,     0, '0,            STAT_OK);
		add_row(ROW_REQ, FN_FREE,    32'h0002_8000, 1, '0,            STAT_OK);
		add_row(ROW_CFG, FN_NONE,    32'd33,        0, '0,            STAT_OK);
		add_row(ROW_REQ, FN_ALLOC,   32'h0000_0000, 1, ADDR_FAIL,     STAT_NOFREE);
		add_row(ROW_CFG, FN_NONE,    32'd41,        0, '0,            STAT_OK);
		add_row(ROW_REQ, FN_ALLOC,   32'h0000_0000, 1, 32'h0002_8000, STAT_OK);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.kind == ROW_CFG) begin
				write_frame_count(row.arg[FC_W-1:0]);
			end else begin
				issue_request(row.fn, row.arg, row.typed, row.exp_address, row.exp_status);
			end
		end

		for (phase = 0; phase < 3; phase++) begin
			tx_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 80 : 0;
			rx_idle_pct = (phase == 0) ? 80 : (phase == 1) ? 15 : 0;
			for (blk = 0; blk < 5; blk++) begin
				write_frame_count(pick_frame_count());
				// response side stalls while requests keep coming: the block backs up
				if (phase == 2 && blk == 2) hold_ask = 400;
				for (i = 0; i < 100; i++) begin
					issue_request(pick_func(), pick_address(), 0, '0, STAT_OK);
				end
			end
		end

		req_bus.valid <= 1'b0;
		while (expected_answers.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("run: %0d requests, %0d frames handed out, %0d allocs refused,", n_req,
			n_granted, n_refused);
		$display("run: %0d out-of-range requests, %0d frame_count writes", n_range, n_cfg);
		if (err_count == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule

// ===== files.f =====
src/bpfa_pkg.sv
src/bpfa_if.sv
src/bpfa_core.sv
src/bitmap_page_frame_allocator_top.sv
test/testbench.sv
